// ===== rtl/core/mpe_pkg.sv =====
// Package for the mouse packet encoder: ring sizing, operation codes,
// controller/datapath command and status structs, delta saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mpe_pkg;

  // Ring buffer sizing (holds RING_DEPTH-1 bytes)
  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Input operation codes
  localparam logic [1:0] MODE_MOTION  = 2'd0;
  localparam logic [1:0] MODE_PRESS   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_READ    = 2'd3;

  // Button id that touches no button bit
  localparam logic [1:0] BTN_OTHER = 2'd3;

  // Packet byte constants
  localparam logic [7:0] SYNC_MARK   = 8'h80;
  localparam logic [7:0] DELTA_POS   = 8'h7F;   // +127
  localparam logic [7:0] DELTA_NEG   = 8'h81;   // -127

  // Packet byte select
  localparam logic [1:0] SEL_HDR = 2'd0;
  localparam logic [1:0] SEL_DX  = 2'd1;
  localparam logic [1:0] SEL_DY  = 2'd2;

  // Result kind
  localparam logic [1:0] RESP_PLAIN = 2'd0;
  localparam logic [1:0] RESP_EMPTY = 2'd1;
  localparam logic [1:0] RESP_READ  = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic       latch;      // capture item, update buttons
    logic       push;       // write one packet byte to the ring
    logic [1:0] push_sel;   // which packet byte
    logic       rd_issue;   // read ring at read pointer, advance it
    logic       load_resp;  // load result registers
    logic [1:0] resp_kind;
  } mpe_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic ring_empty;
    logic zero_motion;      // both live deltas are zero
  } mpe_sts_t;

  // Saturate a signed 16-bit delta to -127..127, as an 8-bit byte
  function automatic logic [7:0] clamp_delta(input logic signed [15:0] d);
    logic [7:0] res;
    if (d > 16'sd127) begin
      res = DELTA_POS;
    end else if (d < -16'sd127) begin
      res = DELTA_NEG;
    end else begin
      res = d[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mpe_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                          wdata,
  output      logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One access per cycle: write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/mpe_ctrl.sv =====
// Sequencer for the mouse packet encoder: decodes an item and steps the
// datapath through byte writes or a ring read. Depends on mpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpe_ctrl
  import mpe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_mode,
  input  wire mpe_sts_t   sts,
  output      logic       busy,
  output      mpe_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH0 = 3'd1;
  localparam logic [2:0] S_PUSH1 = 3'd2;
  localparam logic [2:0] S_PUSH2 = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.push_sel  = SEL_HDR;
    cmd.resp_kind = RESP_PLAIN;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          unique case (in_mode) inside
            MODE_MOTION: begin
              if (sts.zero_motion) begin
                cmd.load_resp = 1'b1;
              end else begin
                state_nxt = S_PUSH0;
              end
            end
            MODE_PRESS, MODE_RELEASE: begin
              state_nxt = S_PUSH0;
            end
            MODE_READ: begin
              if (sts.ring_empty) begin
                cmd.load_resp = 1'b1;
                cmd.resp_kind = RESP_EMPTY;
              end else begin
                cmd.rd_issue = 1'b1;
                state_nxt    = S_READ;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSH0: begin
        cmd.push     = 1'b1;
        cmd.push_sel = SEL_HDR;
        state_nxt    = S_PUSH1;
      end
      S_PUSH1: begin
        cmd.push     = 1'b1;
        cmd.push_sel = SEL_DX;
        state_nxt    = S_PUSH2;
      end
      S_PUSH2: begin
        cmd.push      = 1'b1;
        cmd.push_sel  = SEL_DY;
        cmd.load_resp = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_READ: begin
        cmd.load_resp = 1'b1;
        cmd.resp_kind = RESP_READ;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mpe_dp.sv =====
// Datapath for the mouse packet encoder: button register, item capture,
// ring pointers and RAM, result registers. Depends on mpe_pkg, mpe_ram.
`timescale 1ns / 1ps
`default_nettype none

module mpe_dp
  import mpe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_delta_x,
  input  wire logic [15:0] in_delta_y,
  input  wire logic [1:0]  in_button_id,
  input  wire mpe_cmd_t    cmd,
  output      mpe_sts_t    sts,
  output      logic        out_strobe,
  output      logic [7:0]  out_read_byte,
  output      logic        out_read_empty,
  output      logic        out_bytes_available
);

  logic [2:0]       buttons_r, buttons_nxt;
  logic [7:0]       dx_r, dy_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_inc, rd_inc, ram_addr;
  logic [7:0]       push_byte, ram_rdata;
  logic             ring_full, ram_we;
  logic             strobe_r;
  logic [7:0]       byte_r;
  logic             empty_r, avail_r;

  // Pointer increments modulo ring depth
  assign wr_inc = (wr_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
  assign rd_inc = (rd_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);

  assign ring_full       = (wr_inc == rd_ptr_r);
  assign sts.ring_empty  = (wr_ptr_r == rd_ptr_r);
  assign sts.zero_motion = (in_delta_x == 16'd0) && (in_delta_y == 16'd0);

  // Button update on capture
  always_comb begin
    buttons_nxt = buttons_r;
    if (cmd.latch && in_button_id != BTN_OTHER) begin
      if (in_mode == MODE_PRESS) begin
        buttons_nxt = buttons_r | (3'b001 << in_button_id);
      end else if (in_mode == MODE_RELEASE) begin
        buttons_nxt = buttons_r & ~(3'b001 << in_button_id);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buttons_r <= '0;
    end else begin
      buttons_r <= buttons_nxt;
    end
  end

  // Saturated deltas; button packets carry zero motion
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      if (in_mode == MODE_MOTION) begin
        dx_r <= clamp_delta(in_delta_x);
        dy_r <= clamp_delta(in_delta_y);
      end else begin
        dx_r <= '0;
        dy_r <= '0;
      end
    end
  end

  // Packet byte select
  always_comb begin
    unique case (cmd.push_sel)
      SEL_HDR: push_byte = SYNC_MARK | {5'd0, buttons_r};
      SEL_DX:  push_byte = dx_r;
      SEL_DY:  push_byte = dy_r;
      default: push_byte = '0;
    endcase
  end

  // Ring pointers; a byte that finds the ring full is dropped
  assign ram_we     = cmd.push && !ring_full;
  assign wr_ptr_nxt = ram_we ? wr_inc : wr_ptr_r;
  assign rd_ptr_nxt = cmd.rd_issue ? rd_inc : rd_ptr_r;
  assign ram_addr   = cmd.push ? wr_ptr_r : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  mpe_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (push_byte),
    .rdata (ram_rdata)
  );

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.load_resp;
    end
  end

  // Result payload; availability reflects pointers after this step
  always_ff @(posedge clk) begin
    if (cmd.load_resp) begin
      byte_r  <= (cmd.resp_kind == RESP_READ) ? ram_rdata : 8'd0;
      empty_r <= (cmd.resp_kind == RESP_EMPTY);
      avail_r <= (wr_ptr_nxt != rd_ptr_nxt);
    end
  end

  assign out_strobe          = strobe_r;
  assign out_read_byte       = byte_r;
  assign out_read_empty      = empty_r;
  assign out_bytes_available = avail_r;

endmodule

`default_nettype wire

// ===== rtl/core/mouse_packet_encoder_fifo.sv =====
// Channel   Transfer when           Ports
// -------   ---------------------   ------------------------------------------
// input     start && !busy          in_mode, in_delta_x, in_delta_y, in_button_id
// result    out_strobe (one cycle)  out_read_byte, out_read_empty,
//                                   out_bytes_available
//
// Motion with nonzero delta, press or release: decode, then one ring RAM
// write per packet byte (single port) in S_PUSH0, S_PUSH1 and S_PUSH2.
// Read of a nonempty ring: decode, then S_READ (registered RAM read). Empty
// read and zero motion end at decode. The result strobe comes in the
// cycle after an item's last step, with busy low; the receiver cannot stall.
// Synchronous active-low reset clears buttons and pointers, not the ring.
// Top level: mouse packet encoder with byte ring. Depends on mpe_pkg,
// mpe_ctrl, mpe_dp.
`timescale 1ns / 1ps
`default_nettype none

module mouse_packet_encoder_fifo
  import mpe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  in_mode,
  input  wire logic [15:0] in_delta_x,
  input  wire logic [15:0] in_delta_y,
  input  wire logic [1:0]  in_button_id,
  output      logic        out_strobe,
  output      logic [7:0]  out_read_byte,
  output      logic        out_read_empty,
  output      logic        out_bytes_available
);

  mpe_cmd_t cmd;
  mpe_sts_t sts;

  // Sequencer
  mpe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Datapath
  mpe_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_mode             (in_mode),
    .in_delta_x          (in_delta_x),
    .in_delta_y          (in_delta_y),
    .in_button_id        (in_button_id),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_strobe          (out_strobe),
    .out_read_byte       (out_read_byte),
    .out_read_empty      (out_read_empty),
    .out_bytes_available (out_bytes_available)
  );

endmodule

`default_nettype wire

// ===== tb/sv/mouse_packet_encoder_fifo_tb.sv =====
// Self-checking testbench for mouse_packet_encoder_fifo: directed rows, then
// random event bursts, checked against typed rows or an in-bench predictor.
// Depends on mpe_pkg and the mouse_packet_encoder_fifo RTL.
`timescale 1ns / 1ps

module mouse_packet_encoder_fifo_tb;
  import mpe_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 8;
  localparam int PHASE_EVENTS = 356;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_empty;
    logic       bytes_available;
  } mouse_result_t;

  typedef struct {
    logic [1:0]        mode;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [1:0]        btn;
    logic              typed;
    mouse_result_t     want;
  } event_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [1:0] in_mode;
  logic [15:0] in_delta_x;
  logic [15:0] in_delta_y;
  logic [1:0] in_button_id;
  logic out_strobe;
  logic [7:0] out_read_byte;
  logic out_read_empty;
  logic out_bytes_available;

  // Typed expectation travels with the item, driven like an input
  logic row_typed;
  mouse_result_t row_want;

  // Predictor state
  logic [2:0] btn_state;
  logic [7:0] ring_model [RING_DEPTH];
  int wr_slot;
  int rd_slot;

  mouse_result_t pending_results[$];
  event_row_t directed_rows[$];
  int failures;
  int cycle_count;

  mouse_packet_encoder_fifo dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_delta_x          (in_delta_x),
    .in_delta_y          (in_delta_y),
    .in_button_id        (in_button_id),
    .out_strobe          (out_strobe),
    .out_read_byte       (out_read_byte),
    .out_read_empty      (out_read_empty),
    .out_bytes_available (out_bytes_available)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate a motion delta to -127..127 as a two's complement byte
  function automatic logic [7:0] sat_delta(input logic signed [15:0] d);
    if (d >= 16'sd128) return 8'h7F;
    if (d <= -16'sd128) return 8'h81;
    return d[7:0];
  endfunction

  function automatic mouse_result_t mk_result(input logic [7:0] b, input logic e,
                                              input logic a);
    mouse_result_t r;
    r.read_byte = b;
    r.read_empty = e;
    r.bytes_available = a;
    return r;
  endfunction

  // One byte into the ring model; dropped when the ring is full
  task automatic push_ring(input logic [7:0] b);
    int nxt;
    nxt = (wr_slot + 1) % RING_DEPTH;
    if (nxt != rd_slot) begin
      ring_model[wr_slot] = b;
      wr_slot = nxt;
    end
  endtask

  task automatic queue_packet(input logic [7:0] x, input logic [7:0] y);
    push_ring(SYNC_MARK | {5'b0, btn_state});
    push_ring(x);
    push_ring(y);
  endtask

  // Predict the result of one event and update the model state
  task automatic apply_event(input logic [1:0] mode, input logic signed [15:0] dx,
                             input logic signed [15:0] dy, input logic [1:0] btn,
                             output mouse_result_t res);
    res = '0;
    case (mode)
      MODE_MOTION: begin
        if (dx != 0 || dy != 0) queue_packet(sat_delta(dx), sat_delta(dy));
      end
      MODE_PRESS: begin
        if (btn != BTN_OTHER) btn_state[btn] = 1'b1;
        queue_packet(8'h00, 8'h00);
      end
      MODE_RELEASE: begin
        if (btn != BTN_OTHER) btn_state[btn] = 1'b0;
        queue_packet(8'h00, 8'h00);
      end
      default: begin
        if (wr_slot != rd_slot) begin
          res.read_byte = ring_model[rd_slot];
          rd_slot = (rd_slot + 1) % RING_DEPTH;
        end else begin
          res.read_empty = 1'b1;
        end
      end
    endcase
    res.bytes_available = (wr_slot != rd_slot);
  endtask

  task automatic check_result();
    mouse_result_t want;
    if (pending_results.size() == 0) begin
      $error("result transfer with no event pending");
      failures++;
    end else begin
      want = pending_results.pop_front();
      if (out_read_byte !== want.read_byte) begin
        $error("read_byte: expected %02h, got %02h", want.read_byte, out_read_byte);
        failures++;
      end
      if (out_read_empty !== want.read_empty) begin
        $error("read_empty: expected %0b, got %0b", want.read_empty, out_read_empty);
        failures++;
      end
      if (out_bytes_available !== want.bytes_available) begin
        $error("bytes_available: expected %0b, got %0b", want.bytes_available,
               out_bytes_available);
        failures++;
      end
    end
  endtask

  task automatic record_transfer();
    mouse_result_t res;
    apply_event(in_mode, in_delta_x, in_delta_y, in_button_id, res);
    pending_results.push_back(row_typed ? row_want : res);
  endtask

  // Results are checked before the event accepted on the same edge is recorded
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) check_result();
      if (start && busy === 1'b0) record_transfer();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one event and hold it until the transfer
  task automatic drive_event(input logic [1:0] mode, input logic signed [15:0] dx,
                             input logic signed [15:0] dy, input logic [1:0] btn,
                             input logic typed, input mouse_result_t want);
    start <= 1'b1;
    in_mode <= mode;
    in_delta_x <= dx;
    in_delta_y <= dy;
    in_button_id <= btn;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Sender idles cycle by cycle with the given percentage
  task automatic sender_pause(input int pct);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < pct && gap < 30) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every predicted result has come back
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic signed [15:0] rand_delta();
    case ($urandom_range(0, 9))
      0: return 16'sd0;
      1: begin
        case ($urandom_range(0, 5))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return -16'sd128;
          3: return 16'sd128;
          4: return -16'sd127;
          default: return 16'sd127;
        endcase
      end
      2, 3, 4, 5: return 16'($signed($urandom_range(0, 260)) - 130);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_row(input logic [1:0] mode, input logic signed [15:0] dx,
                         input logic signed [15:0] dy, input logic [1:0] btn,
                         input logic typed, input mouse_result_t want);
    event_row_t r;
    r.mode = mode;
    r.dx = dx;
    r.dy = dy;
    r.btn = btn;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  initial begin
    int idle_pct [4];
    int burst_left;
    int reads_pct;
    int sel;
    logic [1:0] m;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    mouse_result_t none;

    none = '0;
    failures = 0;
    cycle_count = 0;
    btn_state = '0;
    wr_slot = 0;
    rd_slot = 0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_MOTION;
    in_delta_x <= '0;
    in_delta_y <= '0;
    in_button_id <= '0;
    row_typed <= 1'b0;
    row_want <= '0;

    // Directed table: typed rows are obvious from the packet format
    add_row(MODE_READ, 0, 0, 0, 1'b1, mk_result(8'h00, 1'b1, 1'b0));
    add_row(MODE_MOTION, 0, 0, 0, 1'b1, mk_result(8'h00, 1'b0, 1'b0));
    add_row(MODE_MOTION, 16'sh7FFF, 16'sh8000, 0, 1'b1, mk_result(8'h00, 1'b0, 1'b1));
    add_row(MODE_READ, 0, 0, 0, 1'b1, mk_result(8'h80, 1'b0, 1'b1));
    add_row(MODE_READ, 0, 0, 0, 1'b1, mk_result(8'h7F, 1'b0, 1'b1));
    add_row(MODE_READ, 0, 0, 0, 1'b1, mk_result(8'h81, 1'b0, 1'b0));
    add_row(MODE_READ, 0, 0, 0, 1'b1, mk_result(8'h00, 1'b1, 1'b0));
    add_row(MODE_PRESS, 0, 0, 2'd0, 1'b1, mk_result(8'h00, 1'b0, 1'b1));
    add_row(MODE_READ, 0, 0, 0, 1'b1, mk_result(8'h81, 1'b0, 1'b1));
    add_row(MODE_PRESS, 0, 0, 2'd1, 1'b0, none);
    add_row(MODE_PRESS, 0, 0, 2'd2, 1'b0, none);
    add_row(MODE_PRESS, 0, 0, BTN_OTHER, 1'b0, none);
    add_row(MODE_RELEASE, 0, 0, 2'd1, 1'b0, none);
    // release of a button that is not held
    add_row(MODE_RELEASE, 0, 0, 2'd1, 1'b0, none);
    add_row(MODE_RELEASE, 0, 0, BTN_OTHER, 1'b0, none);
    add_row(MODE_MOTION, 16'sd128, -16'sd128, 0, 1'b0, none);
    add_row(MODE_MOTION, 16'sd127, -16'sd127, 0, 1'b0, none);
    add_row(MODE_MOTION, 16'sd1, -16'sd1, 0, 1'b0, none);
    add_row(MODE_MOTION, 16'sd0, 16'sd5, 0, 1'b0, none);
    add_row(MODE_MOTION, 16'sh8000, 16'sd0, 0, 1'b0, none);
    repeat (4) add_row(MODE_READ, 0, 0, 0, 1'b0, none);
    add_row(MODE_RELEASE, 0, 0, 2'd0, 1'b0, none);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      drive_event(directed_rows[i].mode, directed_rows[i].dx, directed_rows[i].dy,
                  directed_rows[i].btn, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // Random bursts: fill bursts overflow the ring, drain bursts empty it
    idle_pct[0] = 0;
    idle_pct[1] = 77;
    idle_pct[2] = 0;
    idle_pct[3] = 30;
    burst_left = 0;
    reads_pct = 45;
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        if (burst_left == 0) begin
          sel = $urandom_range(0, 2);
          reads_pct = (sel == 0) ? 10 : (sel == 1) ? 85 : 45;
          burst_left = $urandom_range(10, 80);
        end
        burst_left--;
        if ($urandom_range(0, 99) < reads_pct) begin
          m = MODE_READ;
        end else begin
          sel = $urandom_range(0, 9);
          m = (sel < 6) ? MODE_MOTION : (sel < 8) ? MODE_PRESS : MODE_RELEASE;
        end
        dx = rand_delta();
        dy = rand_delta();
        // zero motion now and then
        if (m == MODE_MOTION && $urandom_range(0, 19) == 0) begin
          dx = '0;
          dy = '0;
        end
        drive_event(m, dx, dy, 2'($urandom_range(0, 3)), 1'b0, none);
        sender_pause(idle_pct[phase]);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
